FILE: sv/btcr_pkg.sv
// Shared constants and codes for the bitmap text console renderer.
`default_nettype none

package btcr_pkg;

  // Default screen and font geometry
  localparam int ScreenWDef = 320;
  localparam int ScreenHDef = 240;
  localparam int GlyphWDef  = 8;
  localparam int GlyphHDef  = 8;

  // Field widths of the stream items
  localparam int OpW        = 2;
  localparam int CodeW      = 8;
  localparam int GRowW      = 3;
  localparam int RowBitsW   = 8;
  localparam int RdAddrW    = 16;
  localparam int ReadByteW  = 8;
  localparam int CurColW    = 6;
  localparam int CurRowW    = 5;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 24;

  // Pixel values and special characters
  localparam logic [3:0]       InkNibble   = 4'h0;
  localparam logic [3:0]       PaperNibble = 4'hF;
  localparam logic [CodeW-1:0] NewlineCode = 8'd10;

  typedef enum logic [OpW-1:0] {
    OP_DRAW  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

endpackage

`default_nettype wire

FILE: sv/btcr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module btcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/bitmap_text_console_renderer.sv
// Top level of the bitmap text console renderer: sequencer, cursor and memories.
//
// Usage
//   One item enters on the s_axis channel and gives exactly one result on the
//   m_axis channel. Ops: draw character (10 = newline), load one glyph row into
//   the font memory, read one byte of the 4-bit packed frame store.
//   The result carries the read byte (0 unless a read) and the cursor after
//   the item.
// Flow (one item at a time, s_axis_tready low while busy)
//   load, read, unused op : through ST_RESP to the output register.
//   draw                  : paced by the single frame write port, one byte per cycle
//                           within a glyph row, and a read-modify-write for a nibble
//                           that shares a byte with a neighbor outside the cell.
//   newline / wrap at the bottom row: add one scroll, one frame byte per cycle
//                           through the same port.
// Reset
//   rst_ni clears the cursor and starts a clearing pass that zeroes the whole
//   frame store; s_axis_tready stays low meanwhile.
//   The font memory is not cleared: draw only glyphs that were loaded.
// Stall
//   A finished result sits in the output register; the next item is taken while
//   it waits. An item that finishes while the register is still full holds in
//   its last state until m_axis_tready frees the register.
`default_nettype none

module bitmap_text_console_renderer
  import btcr_pkg::*;
#(
  parameter int SCREEN_W = ScreenWDef,
  parameter int SCREEN_H = ScreenHDef,
  parameter int GLYPH_W  = GlyphWDef,
  parameter int GLYPH_H  = GlyphHDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [1:0] op, [9:2] char_code, [12:10] glyph_row, [20:13] row_bits,
  // [36:21] read_address, [39:37] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] read_byte, [13:8] cursor_col, [18:14] cursor_row, [23:19] zero
  output logic      [OutDataW-1:0] m_axis_tdata
);

  // Geometry
  localparam int FrameBytes  = (SCREEN_W * SCREEN_H + 1) / 2;
  localparam int GlyphBytes  = 256 * GLYPH_H;
  localparam int TextCols    = SCREEN_W / GLYPH_W;
  localparam int TextRows    = SCREEN_H / GLYPH_H;
  localparam int ScrollBytes = (SCREEN_W * GLYPH_H) / 2;
  localparam int CopyBytes   = (ScrollBytes >= FrameBytes) ? 0 : FrameBytes - ScrollBytes;
  localparam int RowPix      = SCREEN_W * GLYPH_H;

  // Widths
  localparam int FaW  = $clog2(FrameBytes);
  localparam int GaW  = $clog2(GlyphBytes);
  localparam int PixW = $clog2(SCREEN_W * SCREEN_H + 2);
  localparam int KW   = (GLYPH_H > 2) ? $clog2(GLYPH_H) : 1;
  localparam int JW   = $clog2(GLYPH_W + 1);
  localparam int ColW = ($clog2(TextCols) > CurColW) ? $clog2(TextCols) : CurColW;
  localparam int RowW = ($clog2(TextRows) > CurRowW) ? $clog2(TextRows) : CurRowW;

  typedef enum logic [3:0] {
    ST_CLEAR,   // zero frame bytes from cnt_q to the end
    ST_IDLE,
    ST_RDWAIT,  // frame read data arrives
    ST_BASE,    // pixel address of the cursor's text row
    ST_COL,     // add the column offset
    ST_GLYPH,   // fetch one glyph row
    ST_GWAIT,
    ST_PIX,     // paint one byte, or fetch a byte for a single nibble
    ST_RMW,     // merge a single nibble
    ST_NL,      // next text line
    ST_COPY,    // scroll: move frame up one text row
    ST_RESP     // hand the result to the output register
  } state_e;

  // Input fields
  logic [OpW-1:0]      in_op;
  logic [CodeW-1:0]    in_code;
  logic [GRowW-1:0]    in_grow;
  logic [RowBitsW-1:0] in_rbits;
  logic [RdAddrW-1:0]  in_addr;

  assign in_op    = s_axis_tdata[1:0];
  assign in_code  = s_axis_tdata[9:2];
  assign in_grow  = s_axis_tdata[12:10];
  assign in_rbits = s_axis_tdata[20:13];
  assign in_addr  = s_axis_tdata[36:21];

  // Registers
  state_e               state_q, state_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [CodeW-1:0]     code_q, code_d;
  logic [ReadByteW-1:0] rd_q, rd_d;
  logic [KW-1:0]        k_q, k_d;
  logic [JW-1:0]        j_q, j_d;
  logic [PixW-1:0]      px_q, px_d;
  logic [PixW-1:0]      rowpix_q, rowpix_d;
  logic [RowBitsW-1:0]  bits_q, bits_d;
  logic [FaW-1:0]       cnt_q, cnt_d;
  logic [FaW-1:0]       dst_q, dst_d;
  logic                 cvld_q, cvld_d;
  logic                 seen_q, seen_d;
  logic                 ovld_q, ovld_d;
  logic [ReadByteW-1:0] ord_q, ord_d;
  logic [CurColW-1:0]   ocol_q, ocol_d;
  logic [CurRowW-1:0]   orow_q, orow_d;

  // Memory ports
  logic                 fb_we, fb_re;
  logic [FaW-1:0]       fb_waddr, fb_raddr;
  logic [7:0]           fb_wdata, fb_rdata;
  logic                 gl_we, gl_re;
  logic [GaW-1:0]       gl_waddr, gl_raddr;
  logic [7:0]           gl_rdata;

  logic                 accept;
  logic                 out_free;
  logic [PixW-2:0]      byte_addr;
  logic                 byte_ok;
  logic                 pair_ok;
  logic [3:0]           nib0, nib1;
  logic [JW-1:0]        j_nx;
  logic [PixW-1:0]      px_nx;
  logic                 step_go;
  logic                 step_two;

  // Nibble painted for glyph column j: ink for a set bit, paper otherwise
  function automatic logic [3:0] nib_f(input logic [7:0] bits, input logic [4:0] j);
    logic [3:0] n;
    n = PaperNibble;
    if (j < 5'd8) begin
      if (bits[3'(3'd7 - j[2:0])]) n = InkNibble;
    end
    return n;
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !ovld_q || m_axis_tready;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {5'd0, orow_q, ocol_q, ord_q};

  assign byte_addr = px_q[PixW-1:1];
  assign byte_ok   = 32'(byte_addr) < FrameBytes;
  assign pair_ok   = !px_q[0] && (32'(j_q) + 1 < GLYPH_W);
  assign nib0      = nib_f(bits_q, 5'(j_q));
  assign nib1      = nib_f(bits_q, 5'(j_q) + 5'd1);

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    code_d   = code_q;
    rd_d     = rd_q;
    k_d      = k_q;
    j_d      = j_q;
    px_d     = px_q;
    rowpix_d = rowpix_q;
    bits_d   = bits_q;
    cnt_d    = cnt_q;
    dst_d    = dst_q;
    cvld_d   = 1'b0;
    seen_d   = seen_q;
    ord_d    = ord_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    ovld_d   = ovld_q && !m_axis_tready;

    fb_we    = 1'b0;
    fb_waddr = '0;
    fb_wdata = '0;
    fb_re    = 1'b0;
    fb_raddr = '0;
    gl_we    = 1'b0;
    gl_waddr = GaW'(in_code) * GaW'(GLYPH_H) + GaW'(in_grow);
    gl_re    = 1'b0;
    gl_raddr = GaW'(code_q) * GaW'(GLYPH_H) + GaW'(k_q);

    step_go  = 1'b0;
    step_two = 1'b0;

    // Copied byte from the previous scroll read
    if (cvld_q) begin
      fb_we    = 1'b1;
      fb_waddr = dst_q;
      fb_wdata = fb_rdata;
    end

    unique case (state_q)
      ST_CLEAR: begin
        fb_we    = 1'b1;
        fb_waddr = cnt_q;
        fb_wdata = '0;
        cnt_d    = cnt_q + FaW'(1);
        if (cnt_q == FaW'(FrameBytes - 1)) begin
          state_d = seen_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          seen_d = 1'b1;
          code_d = in_code;
          rd_d   = '0;
          unique case (op_e'(in_op))
            OP_DRAW: state_d = (in_code == NewlineCode) ? ST_NL : ST_BASE;
            OP_LOAD: begin
              gl_we   = 32'(in_grow) < GLYPH_H;
              state_d = ST_RESP;
            end
            OP_READ: begin
              if (32'(in_addr) < FrameBytes) begin
                fb_re    = 1'b1;
                fb_raddr = FaW'(in_addr);
                state_d  = ST_RDWAIT;
              end else begin
                state_d = ST_RESP;
              end
            end
            OP_NONE: state_d = ST_RESP;
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_RDWAIT: begin
        rd_d    = fb_rdata;
        state_d = ST_RESP;
      end
      ST_BASE: begin
        px_d    = PixW'(row_q) * PixW'(RowPix);
        k_d     = '0;
        state_d = ST_COL;
      end
      ST_COL: begin
        px_d     = px_q + PixW'(col_q) * PixW'(GLYPH_W);
        rowpix_d = px_q + PixW'(col_q) * PixW'(GLYPH_W);
        state_d  = ST_GLYPH;
      end
      ST_GLYPH: begin
        gl_re   = 1'b1;
        state_d = ST_GWAIT;
      end
      ST_GWAIT: begin
        bits_d  = gl_rdata;
        j_d     = '0;
        px_d    = rowpix_q;
        state_d = ST_PIX;
      end
      ST_PIX: begin
        if (pair_ok && byte_ok) begin
          fb_we    = 1'b1;
          fb_waddr = FaW'(byte_addr);
          fb_wdata = {nib0, nib1};
          step_go  = 1'b1;
          step_two = 1'b1;
        end else if (byte_ok) begin
          fb_re    = 1'b1;
          fb_raddr = FaW'(byte_addr);
          state_d  = ST_RMW;
        end else begin
          step_go = 1'b1;
        end
      end
      ST_RMW: begin
        fb_we    = 1'b1;
        fb_waddr = FaW'(byte_addr);
        fb_wdata = px_q[0] ? {fb_rdata[7:4], nib0} : {nib0, fb_rdata[3:0]};
        step_go  = 1'b1;
      end
      ST_NL: begin
        col_d = '0;
        if (row_q == RowW'(TextRows - 1)) begin
          cnt_d   = '0;
          state_d = ST_COPY;
        end else begin
          row_d   = row_q + RowW'(1);
          state_d = ST_RESP;
        end
      end
      ST_COPY: begin
        if (cnt_q == FaW'(CopyBytes)) begin
          state_d = ST_CLEAR;
        end else begin
          fb_re    = 1'b1;
          fb_raddr = cnt_q + FaW'(ScrollBytes);
          dst_d    = cnt_q;
          cvld_d   = 1'b1;
          cnt_d    = cnt_q + FaW'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ord_d   = rd_q;
          ocol_d  = col_q[CurColW-1:0];
          orow_d  = row_q[CurRowW-1:0];
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Advance across the glyph cell after a pixel step
    j_nx  = j_q + (step_two ? JW'(2) : JW'(1));
    px_nx = px_q + (step_two ? PixW'(2) : PixW'(1));
    if (step_go) begin
      if (j_nx >= JW'(GLYPH_W)) begin
        if (k_q == KW'(GLYPH_H - 1)) begin
          if (col_q == ColW'(TextCols - 1)) begin
            state_d = ST_NL;
          end else begin
            col_d   = col_q + ColW'(1);
            state_d = ST_RESP;
          end
        end else begin
          k_d      = k_q + KW'(1);
          rowpix_d = rowpix_q + PixW'(SCREEN_W);
          state_d  = ST_GLYPH;
        end
      end else begin
        j_d     = j_nx;
        px_d    = px_nx;
        state_d = ST_PIX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      col_q    <= '0;
      row_q    <= '0;
      code_q   <= '0;
      rd_q     <= '0;
      k_q      <= '0;
      j_q      <= '0;
      px_q     <= '0;
      rowpix_q <= '0;
      bits_q   <= '0;
      cnt_q    <= '0;
      dst_q    <= '0;
      cvld_q   <= 1'b0;
      seen_q   <= 1'b0;
      ovld_q   <= 1'b0;
      ord_q    <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      code_q   <= code_d;
      rd_q     <= rd_d;
      k_q      <= k_d;
      j_q      <= j_d;
      px_q     <= px_d;
      rowpix_q <= rowpix_d;
      bits_q   <= bits_d;
      cnt_q    <= cnt_d;
      dst_q    <= dst_d;
      cvld_q   <= cvld_d;
      seen_q   <= seen_d;
      ovld_q   <= ovld_d;
      ord_q    <= ord_d;
      ocol_q   <= ocol_d;
      orow_q   <= orow_d;
    end
  end

  // Frame store, packed 4-bit pixels
  btcr_ram #(
    .Width (8),
    .Depth (FrameBytes)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .re_i    (fb_re),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rdata)
  );

  // Font memory, GLYPH_H rows per character
  btcr_ram #(
    .Width (8),
    .Depth (GlyphBytes)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (gl_we),
    .waddr_i (gl_waddr),
    .wdata_i (in_rbits),
    .re_i    (gl_re),
    .raddr_i (gl_raddr),
    .rdata_o (gl_rdata)
  );

`ifndef NO_ASSERTIONS
  // Cursor stays inside the text grid
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < TextCols) && (32'(row_q) < TextRows))
    else $error("cursor outside text grid");

  // Frame writes stay inside the store
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_we |-> (32'(fb_waddr) < FrameBytes))
    else $error("frame write out of range");

  // Scroll source always leads the destination, so no byte is read after overwrite
  a_scroll_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fb_re && cvld_q) |-> (fb_raddr > dst_q))
    else $error("scroll read behind write");

  // One item at a time: a transfer in drops ready for the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_bitmap_text_console_renderer.sv
// Self-checking stream testbench for the bitmap text console renderer.
`timescale 1ns / 1ps

module tb_bitmap_text_console_renderer;
  import btcr_pkg::*;

  // Geometry follows the block's default parameters
  localparam int ScreenW     = ScreenWDef;
  localparam int ScreenH     = ScreenHDef;
  localparam int GlyphW      = GlyphWDef;
  localparam int GlyphH      = GlyphHDef;
  localparam int FrameBytes  = (ScreenW * ScreenH + 1) / 2;
  localparam int FontBytes   = 256 * GlyphH;
  localparam int TextCols    = ScreenW / GlyphW;
  localparam int TextRows    = ScreenH / GlyphH;
  localparam int ScrollBytes = (ScreenW * GlyphH) / 2;

  localparam int ItemTarget   = 900;  // useful random-phase transfers
  localparam int ItemsPerScroll = 100; // pacing: scrolls cost a full store walk
  localparam int DrainEvery   = 150;  // sender waits for all results this often
  localparam int HoldAtItem   = 300;  // receiver backpressure kicks in here
  localparam int HoldCycles   = 1500;
  localparam int SettleCycles = 100;
  localparam int ShowErrors   = 10;

  // Input transfer, op in the lowest bits
  typedef struct packed {
    logic [InDataW-OpW-CodeW-GRowW-RowBitsW-RdAddrW-1:0] spare;
    logic [RdAddrW-1:0]  read_address;
    logic [RowBitsW-1:0] row_bits;
    logic [GRowW-1:0]    glyph_row;
    logic [CodeW-1:0]    char_code;
    op_e                 op;
  } console_cmd_t;

  // Output transfer, read byte in the lowest bits
  typedef struct packed {
    logic [OutDataW-ReadByteW-CurColW-CurRowW-1:0] spare;
    logic [CurRowW-1:0]   cursor_row;
    logic [CurColW-1:0]   cursor_col;
    logic [ReadByteW-1:0] read_byte;
  } console_status_t;

  typedef struct {
    console_cmd_t    cmd;
    console_status_t res;
    bit              drain_first;  // hold until every earlier result is back
  } plan_entry_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [1:0] op, [9:2] char_code, [12:10] glyph_row, [20:13] row_bits,
  // [36:21] read_address, [39:37] zero
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] read_byte, [13:8] cursor_col, [18:14] cursor_row, [23:19] zero
  logic [OutDataW-1:0] m_axis_tdata;

  bitmap_text_console_renderer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Console shadow: frame store, font and cursor as the block should hold them
  // ---------------------------------------------------------------------------
  logic [7:0]        fb_shadow   [FrameBytes];
  logic [7:0]        font_shadow [FontBytes];
  int unsigned       cur_col;
  int unsigned       cur_row;
  int                scroll_count;

  // Stimulus bookkeeping
  plan_entry_t       cmd_plan_q [$];
  console_status_t   status_due_q [$];   // status words owed by the block
  logic [GlyphH-1:0] rows_loaded [256];  // which font rows were ever written
  int                drawable_q [$];     // codes whose whole glyph is loaded
  bit                drain_next;

  int                items_sent;
  int                results_seen;
  int                error_count;
  int                cycle_count;
  int                cycle_limit = 32'h7fff_ffff;

  function automatic void put_pixel(int unsigned pix, logic [3:0] val);
    int unsigned idx = pix >> 1;
    if (idx >= FrameBytes) return;
    // even pixel lives in the high nibble
    if (pix[0] == 1'b0) fb_shadow[idx][7:4] = val;
    else                fb_shadow[idx][3:0] = val;
  endfunction

  function automatic void scroll_text_up();
    scroll_count++;
    for (int i = 0; i < FrameBytes; i++) begin
      if (ScrollBytes < FrameBytes && i < FrameBytes - ScrollBytes)
        fb_shadow[i] = fb_shadow[i + ScrollBytes];
      else
        fb_shadow[i] = 8'h00;
    end
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    if (cur_row >= TextRows - 1) scroll_text_up();
    else cur_row++;
  endfunction

  function automatic void paint_glyph(logic [CodeW-1:0] code);
    int unsigned base = cur_row * GlyphH * ScreenW + cur_col * GlyphW;
    logic [7:0]  bits;
    bit          ink;
    for (int k = 0; k < GlyphH; k++) begin
      bits = font_shadow[int'(code) * GlyphH + k];
      for (int j = 0; j < GlyphW; j++) begin
        // columns past bit 0 of a wide glyph are always paper
        ink = (j < 8) && bits[7 - j];
        put_pixel(base + k * ScreenW + j, ink ? InkNibble : PaperNibble);
      end
    end
    cur_col++;
    if (cur_col >= TextCols) line_feed();
  endfunction

  // Applies one command to the shadow and returns the status word it yields
  function automatic console_status_t apply_console_cmd(console_cmd_t cmd);
    console_status_t st;
    st = '0;
    case (cmd.op)
      OP_DRAW: begin
        if (cmd.char_code == NewlineCode) line_feed();
        else paint_glyph(cmd.char_code);
      end
      OP_LOAD: begin
        if (cmd.glyph_row < GlyphH)
          font_shadow[int'(cmd.char_code) * GlyphH + cmd.glyph_row] = cmd.row_bits;
      end
      OP_READ: begin
        if (cmd.read_address < FrameBytes) st.read_byte = fb_shadow[cmd.read_address];
      end
      default: ;
    endcase
    st.cursor_col = CurColW'(cur_col);
    st.cursor_row = CurRowW'(cur_row);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic console_cmd_t make_cmd(op_e op, logic [CodeW-1:0] code,
                                            logic [GRowW-1:0] grow,
                                            logic [RowBitsW-1:0] bits,
                                            logic [RdAddrW-1:0] addr);
    console_cmd_t c;
    c              = '0;
    c.op           = op;
    c.char_code    = code;
    c.glyph_row    = grow;
    c.row_bits     = bits;
    c.read_address = addr;
    return c;
  endfunction

  function automatic void queue_cmd(console_cmd_t cmd);
    plan_entry_t e;
    bit          was_full;
    e.cmd         = cmd;
    e.res         = apply_console_cmd(cmd);
    e.drain_first = drain_next;
    drain_next    = 1'b0;
    cmd_plan_q.push_back(e);
    if (cmd.op == OP_LOAD && cmd.glyph_row < GlyphH) begin
      was_full = &rows_loaded[cmd.char_code];
      rows_loaded[cmd.char_code][cmd.glyph_row] = 1'b1;
      if (!was_full && &rows_loaded[cmd.char_code]) drawable_q.push_back(cmd.char_code);
    end
  endfunction

  // Draw or newline; a scroll is only let through at a paced rate since each
  // one walks the whole frame store, otherwise a read goes out instead.
  function automatic void queue_draw(logic [CodeW-1:0] code);
    bit scrolls;
    scrolls = (cur_row == TextRows - 1) &&
              (code == NewlineCode || cur_col == TextCols - 1);
    if (scrolls && scroll_count >= 1 + cmd_plan_q.size() / ItemsPerScroll)
      queue_cmd(make_cmd(OP_READ, code, 3'($urandom), 8'($urandom),
                         16'($urandom_range(0, FrameBytes - 1))));
    else
      queue_cmd(make_cmd(OP_DRAW, code, 3'($urandom), 8'($urandom), 16'($urandom)));
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void log_mismatch(string msg);
    error_count++;
    if (error_count <= ShowErrors) $display("%0t mismatch: %s", $time, msg);
  endfunction

  function automatic void check_status(console_status_t got);
    console_status_t want;
    if (status_due_q.size() == 0) begin
      log_mismatch($sformatf("result %h with nothing outstanding", got));
      return;
    end
    want = status_due_q.pop_front();
    if (got.read_byte !== want.read_byte)
      log_mismatch($sformatf("read_byte exp %h got %h", want.read_byte, got.read_byte));
    if (got.cursor_col !== want.cursor_col)
      log_mismatch($sformatf("cursor_col exp %0d got %0d", want.cursor_col, got.cursor_col));
    if (got.cursor_row !== want.cursor_row)
      log_mismatch($sformatf("cursor_row exp %0d got %0d", want.cursor_row, got.cursor_row));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers planned transfers with random gaps and drain points
  // ---------------------------------------------------------------------------
  plan_entry_t     nxt;
  console_status_t offered_res;
  bit              took;
  int              tx_gap;
  int              tx_burst;
  int              gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      items_sent    <= 0;
      tx_gap        <= 0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        status_due_q.push_back(offered_res);
        items_sent <= items_sent + 1;
      end
      if (s_axis_tvalid && !took) begin
        // keep offering the same transfer
      end else if (tx_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        tx_gap        <= tx_gap - 1;
      end else if (cmd_plan_q.size() != 0 &&
                   !(cmd_plan_q[0].drain_first && (took || results_seen != items_sent))) begin
        nxt           = cmd_plan_q.pop_front();
        offered_res   = nxt.res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.cmd;
        // gap that follows this transfer: mostly none or short, rarely long,
        // with occasional back-to-back stretches
        if (tx_burst != 0) begin
          tx_burst = tx_burst - 1;
          gap      = 0;
        end else begin
          case ($urandom_range(0, 49))
            0:          begin tx_burst = $urandom_range(30, 80); gap = 0; end
            1:          gap = $urandom_range(20, 60);
            2, 3, 4, 5: gap = $urandom_range(4, 15);
            default:    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
          endcase
        end
        tx_gap <= gap;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result, random backpressure
  // ---------------------------------------------------------------------------
  int rx_stall;
  int rx_burst;
  int rx_hold_left;
  bit rx_hold_armed;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      results_seen  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_status(m_axis_tdata);
        results_seen <= results_seen + 1;
      end
      if (rx_hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_stall != 0) begin
        m_axis_tready <= 1'b0;
        rx_stall = rx_stall - 1;
      end else if (rx_burst != 0) begin
        m_axis_tready <= 1'b1;
        rx_burst = rx_burst - 1;
      end else begin
        case ($urandom_range(0, 19))
          0:       begin rx_burst = $urandom_range(40, 120); m_axis_tready <= 1'b1; end
          1:       begin rx_stall = $urandom_range(10, 40);  m_axis_tready <= 1'b0; end
          2, 3, 4: begin rx_stall = $urandom_range(0, 2);    m_axis_tready <= 1'b0; end
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // One long receiver hold-off so the output register fills and the input stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_left  <= 0;
      rx_hold_armed <= 1'b1;
    end else if (rx_hold_armed && items_sent >= HoldAtItem) begin
      rx_hold_left  <= HoldCycles;
      rx_hold_armed <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= cycle_limit) begin
      $display("tb_bitmap_text_console_renderer: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Plan, reset, end of run
  // ---------------------------------------------------------------------------
  logic [7:0] pattern_rows [8] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F};

  initial begin
    int          useful;
    int          drains_done;
    int          first_new;
    int          r;
    int          c;
    int          addr;
    logic [7:0]  code;

    foreach (fb_shadow[i])   fb_shadow[i]   = 8'h00;
    foreach (font_shadow[i]) font_shadow[i] = 8'h00;
    foreach (rows_loaded[i]) rows_loaded[i] = '0;
    cur_col      = 0;
    cur_row      = 0;
    scroll_count = 0;
    drain_next   = 1'b0;

    // Directed: one glyph with edge rows, drawn and four of its pixel pairs read back
    for (int k = 0; k < GlyphH; k++)
      queue_cmd(make_cmd(OP_LOAD, 8'hFF, 3'(k), pattern_rows[k % 8], 16'h0000));
    queue_draw(8'hFF);
    for (int k = 0; k < 4; k++)
      queue_cmd(make_cmd(OP_READ, 8'h00, 3'd0, 8'h00, 16'(k * ScreenW / 2 + k)));
    // last byte of the store, then two addresses past it
    queue_cmd(make_cmd(OP_READ, 8'h00, 3'd0, 8'h00, 16'(FrameBytes - 1)));
    queue_cmd(make_cmd(OP_READ, 8'h00, 3'd0, 8'h00, 16'(FrameBytes)));
    queue_cmd(make_cmd(OP_READ, 8'h00, 3'd0, 8'h00, 16'hFFFF));
    // unused op with every field bit set must change nothing
    queue_cmd(make_cmd(OP_NONE, 8'hFF, 3'h7, 8'hFF, 16'hFFFF));
    queue_draw(NewlineCode);
    queue_draw(8'hFF);
    queue_cmd(make_cmd(OP_READ, 8'h00, 3'd0, 8'h00, 16'(GlyphH * ScreenW / 2)));
    queue_cmd(make_cmd(OP_LOAD, 8'h00, 3'd0, 8'h00, 16'h0000));

    // Random: sequences of glyph loads, text runs, read-backs and noise
    drain_next  = 1'b1;
    useful      = 0;
    drains_done = 0;
    while (useful < ItemTarget) begin
      first_new = cmd_plan_q.size();
      case ($urandom_range(0, 9))
        0, 1: begin
          code = 8'($urandom);
          if ($urandom_range(0, 5) == 0) begin
            // partial glyph: leaves the code undrawable until completed
            repeat ($urandom_range(1, 4))
              queue_cmd(make_cmd(OP_LOAD, code, 3'($urandom_range(0, GlyphH - 1)),
                                 8'($urandom), 16'($urandom)));
          end else begin
            for (int k = 0; k < GlyphH; k++)
              queue_cmd(make_cmd(OP_LOAD, code, 3'(k), 8'($urandom), 16'($urandom)));
          end
        end
        2, 3, 4, 5: begin
          repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 9) == 0) queue_draw(NewlineCode);
            else queue_draw(8'(drawable_q[$urandom_range(0, drawable_q.size() - 1)]));
          end
        end
        6, 7: begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
              0, 1:    addr = $urandom_range(FrameBytes, 16'hFFFF);
              2, 3, 4: addr = $urandom_range(0, FrameBytes - 1);
              default: begin
                // pixel pair inside a recently drawn cell or any row above
                r = ($urandom_range(0, 1) == 0) ? cur_row : $urandom_range(0, cur_row);
                c = ($urandom_range(0, 1) == 0 && cur_col != 0) ?
                    cur_col - 1 : $urandom_range(0, TextCols - 1);
                addr = ((r * GlyphH + $urandom_range(0, GlyphH - 1)) * ScreenW +
                        c * GlyphW) / 2 + $urandom_range(0, GlyphW / 2 - 1);
              end
            endcase
            queue_cmd(make_cmd(OP_READ, 8'($urandom), 3'($urandom), 8'($urandom),
                               16'(addr)));
          end
        end
        8: begin
          queue_cmd(make_cmd(OP_NONE, 8'($urandom), 3'($urandom), 8'($urandom),
                             16'($urandom)));
        end
        default: begin
          repeat ($urandom_range(1, 5)) queue_draw(NewlineCode);
        end
      endcase
      foreach (cmd_plan_q[i])
        if (i >= first_new && cmd_plan_q[i].cmd.op != OP_NONE) useful++;
      if (cmd_plan_q.size() / DrainEvery > drains_done) begin
        drains_done++;
        drain_next = 1'b1;
      end
    end

    // Slowest case: clearing pass, every scroll, every transfer at worst gaps
    cycle_limit = 4 * ((scroll_count + 1) * (FrameBytes + 2) +
                       cmd_plan_q.size() * 300 + HoldCycles + 1000);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(cmd_plan_q.size() == 0 && !s_axis_tvalid && results_seen == items_sent))
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (status_due_q.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", status_due_q.size()));
    if (error_count == 0)
      $display("tb_bitmap_text_console_renderer: done, clean");
    else
      $display("tb_bitmap_text_console_renderer: done, errors");
    $finish;
  end

endmodule

FILE: files.f
sv/btcr_pkg.sv
sv/btcr_ram.sv
sv/bitmap_text_console_renderer.sv
verif/tb_bitmap_text_console_renderer.sv
